// ===== design/agrf_pkg.sv =====
// ----------------------------------------------------------------------------
// agrf_pkg: shared types and constants for the alignment gap run finder
// Field widths, byte codes and the transfer payload structs.
// ----------------------------------------------------------------------------
package agrf_pkg;

	localparam int POS_BITS  = 32;
	localparam int REC_BITS  = 16;
	localparam int FILE_BITS = 16;
	localparam int CFG_BITS  = 32;

	localparam logic [7:0] GAP_CHAR     = 8'h2D;
	localparam logic [7:0] HEADER_CHAR  = 8'h3E;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	localparam logic [CFG_BITS-1:0] MIN_GAP_RESET = CFG_BITS'(10);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} agrf_in_t;

	typedef struct packed {
		logic                 is_error;
		logic [FILE_BITS-1:0] file_number;
		logic [REC_BITS-1:0]  record_number;
		logic [POS_BITS-1:0]  gap_begin;
		logic [POS_BITS-1:0]  gap_finish;
	} agrf_res_t;

endpackage

// ===== design/agrf_scan.sv =====
// ----------------------------------------------------------------------------
// agrf_scan: per-byte scanner state and result decode
// Holds the line/header/gap state; computes next state and the optional
// result for the byte presented on item; the state advances when step is high.
// ----------------------------------------------------------------------------
module agrf_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  agrf_pkg::agrf_in_t             item,
	input  logic [agrf_pkg::CFG_BITS-1:0]  min_gap_length,
	output logic                           hit,
	output agrf_pkg::agrf_res_t            result
);
	import agrf_pkg::*;

	typedef struct packed {
		logic                 at_line_start;
		logic                 in_header_line;
		logic                 header_has_token;
		logic                 gap_open;
		logic [POS_BITS-1:0]  column_position;
		logic [POS_BITS-1:0]  run_start;
		logic [REC_BITS-1:0]  record_count;
		logic [FILE_BITS-1:0] file_count;
		logic                 skip_until_eof;
	} scan_state_t;

	// everything clear except the line-start flag
	localparam scan_state_t ST_RESET = '{1'b1, 1'b0, 1'b0, 1'b0, '0, '0, '0, '0, 1'b0};

	scan_state_t st_q;
	scan_state_t st_nxt;

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	// run length (zero when end does not pass start) against threshold
	function automatic logic gap_long_enough(input logic [POS_BITS-1:0] col,
	                                         input logic [POS_BITS-1:0] start,
	                                         input logic [CFG_BITS-1:0] min_len);
		logic [POS_BITS-1:0] len;
		len = (col > start) ? (col - start) : '0;
		return len >= POS_BITS'(min_len);
	endfunction

	always_comb begin
		logic [7:0] b;
		logic       eof;
		logic       blank;
		b      = item.data_byte;
		eof    = item.end_of_file;
		blank  = is_blank(b);
		st_nxt = st_q;
		hit    = 1'b0;
		result = '0;

		if (!st_q.skip_until_eof) begin
			if (st_q.in_header_line) begin
				if (b == NEWLINE_CHAR) begin
					st_nxt.in_header_line = 1'b0;
					if (!st_nxt.header_has_token) begin
						st_nxt.skip_until_eof = 1'b1;
						hit                   = 1'b1;
						result.is_error       = 1'b1;
						result.file_number    = st_nxt.file_count;
						result.record_number  = st_nxt.record_count;
					end else begin
						if (st_nxt.gap_open) begin
							st_nxt.gap_open = 1'b0;
							if (gap_long_enough(st_nxt.column_position, st_nxt.run_start,
							                    min_gap_length)) begin
								hit                  = 1'b1;
								result.file_number   = st_nxt.file_count;
								result.record_number = st_nxt.record_count;
								result.gap_begin     = st_nxt.run_start;
								result.gap_finish    = st_nxt.column_position;
							end
						end
						st_nxt.column_position = '0;
						if (st_nxt.record_count != '1)
							st_nxt.record_count = st_nxt.record_count + REC_BITS'(1);
					end
					st_nxt.at_line_start = 1'b1;
				end else if (!blank) begin
					st_nxt.header_has_token = 1'b1;
				end
			end else if (st_q.at_line_start && b == HEADER_CHAR) begin
				st_nxt.in_header_line   = 1'b1;
				st_nxt.header_has_token = 1'b0;
				st_nxt.at_line_start    = 1'b0;
			end else begin
				st_nxt.at_line_start = (b == NEWLINE_CHAR);
				if (!blank) begin
					if (b == GAP_CHAR) begin
						if (!st_q.gap_open) begin
							st_nxt.run_start = st_q.column_position;
							st_nxt.gap_open  = 1'b1;
						end
					end else if (st_q.gap_open) begin
						st_nxt.gap_open = 1'b0;
						if (gap_long_enough(st_q.column_position, st_q.run_start,
						                    min_gap_length)) begin
							hit                  = 1'b1;
							result.file_number   = st_q.file_count;
							result.record_number = st_q.record_count;
							result.gap_begin     = st_q.run_start;
							result.gap_finish    = st_q.column_position;
						end
					end
					if (st_q.column_position != '1)
						st_nxt.column_position = st_q.column_position + POS_BITS'(1);
				end
			end

			// end of file: judge an unfinished header or flush an open gap
			if (eof && !hit) begin
				if (st_nxt.in_header_line) begin
					st_nxt.in_header_line = 1'b0;
					if (!st_nxt.header_has_token) begin
						hit                  = 1'b1;
						result.is_error      = 1'b1;
						result.file_number   = st_nxt.file_count;
						result.record_number = st_nxt.record_count;
					end else if (st_nxt.gap_open && gap_long_enough(
						st_nxt.column_position, st_nxt.run_start, min_gap_length)) begin
						hit                  = 1'b1;
						result.file_number   = st_nxt.file_count;
						result.record_number = st_nxt.record_count;
						result.gap_begin     = st_nxt.run_start;
						result.gap_finish    = st_nxt.column_position;
					end
				end else if (st_nxt.gap_open && gap_long_enough(
					st_nxt.column_position, st_nxt.run_start, min_gap_length)) begin
					hit                  = 1'b1;
					result.file_number   = st_nxt.file_count;
					result.record_number = st_nxt.record_count;
					result.gap_begin     = st_nxt.run_start;
					result.gap_finish    = st_nxt.column_position;
				end
			end
		end

		// per-file state returns to reset, file index advances
		if (eof) begin
			st_nxt.at_line_start    = 1'b1;
			st_nxt.in_header_line   = 1'b0;
			st_nxt.header_has_token = 1'b0;
			st_nxt.gap_open         = 1'b0;
			st_nxt.column_position  = '0;
			st_nxt.run_start        = '0;
			st_nxt.record_count     = '0;
			st_nxt.skip_until_eof   = 1'b0;
			if (st_q.file_count != '1)
				st_nxt.file_count = st_q.file_count + FILE_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (step) begin
			st_q <= st_nxt;
		end
	end

endmodule

// ===== design/alignment_gap_run_finder.sv =====
// ----------------------------------------------------------------------------
// alignment_gap_run_finder: FASTA alignment gap run reporter
// Scans file bytes, tracks records and columns, reports long '-' runs and
// headers with an empty identifier.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload      direction
//  -------   ---------------------   ----------   ---------
//  byte      byte_valid/byte_stall   byte_item    into block, one file byte
//  result    result_valid/_stall     result_item  out of block, gap or error
//  cfg       cfg_valid/cfg_ready     cfg_data     into block, min_gap_length
//
// One byte per cycle sustained while the result register is not stalled and
// full. A byte is registered on transfer into the byte stage, decoded against
// the scanner state and its result (if any) lands in the result register,
// which drives result_valid and result_item.
// Reset (arst_n low) returns the scanner state to its reset values (line-start
// flag set, all else clear) and sets min_gap_length to 10. When the result
// register is stalled and full and the byte stage holds a byte, that stage holds
// and byte_stall rises; the stall path from result_stall to byte_stall is combinational. cfg_ready is always high.
//
module alignment_gap_run_finder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  agrf_pkg::agrf_in_t             byte_item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output agrf_pkg::agrf_res_t            result_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [agrf_pkg::CFG_BITS-1:0]  cfg_data
);
	import agrf_pkg::*;

	logic                item_valid_s1;
	agrf_in_t            item_s1;
	logic [CFG_BITS-1:0] min_gap_q;
	logic                res_valid_q;
	agrf_res_t           res_q;

	logic      advance;
	logic      hit;
	agrf_res_t result;

	// the byte stage moves on whenever the result register is free or draining
	assign advance    = item_valid_s1 && (!res_valid_q || !result_stall);
	assign byte_stall = item_valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_gap_q <= cfg_data;
		end
	end

	// byte stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			item_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid)
			item_s1 <= byte_item;
	end

	agrf_scan u_scan (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.item           (item_s1),
		.min_gap_length (min_gap_q),
		.hit            (hit),
		.result         (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= hit;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit)
			res_q <= result;
	end

	assign result_valid = res_valid_q;
	assign result_item  = res_q;

`ifndef NO_ASSERTIONS
	a_byte_lands: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> item_valid_s1)
		else $error("transferred byte did not reach the byte stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> item_valid_s1 && res_valid_q && result_stall)
		else $error("byte stage stalled without a blocked result");

	a_error_no_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_item.is_error |->
		result_item.gap_begin == '0 && result_item.gap_finish == '0)
		else $error("error result carries a gap span");

	a_gap_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.is_error |->
		result_item.gap_begin <= result_item.gap_finish)
		else $error("gap report ends before it begins");
`endif

endmodule
